FILE: rtl/ptp_measurement_cache_unit_macros.svh
// ----------------------------------------------------------------------------
// PTP measurement cache assertion macros
// Short forms for the concurrent checks of the measurement cache.
// ----------------------------------------------------------------------------
`ifndef PTP_MEASUREMENT_CACHE_UNIT_MACROS_SVH
`define PTP_MEASUREMENT_CACHE_UNIT_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define PMC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ptp measurement cache: assertion failed");

// consequent holds in the cycle after the antecedent
`define PMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ptp measurement cache: assertion failed");

`endif

FILE: rtl/ptpmc_pkg.sv
// ----------------------------------------------------------------------------
// PTP measurement cache package
// Operation codes, record key type and default sizes of the cache.
// ----------------------------------------------------------------------------
package ptpmc_pkg;

	localparam int DEF_ENTRIES = 4;

	localparam int FUNC_W  = 2;
	localparam int SEL_W   = 2;
	localparam int TIME_W  = 64;
	localparam int IN_W    = 184;
	localparam int OUT_W   = 200;

	localparam logic [FUNC_W-1:0] FUNC_PUSH   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_RECORD = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

	// field order from the lowest bit up: domain, sdo, seq, clock, port number
	typedef struct packed {
		logic [15:0] portnum;
		logic [63:0] clock;
		logic [15:0] seq;
		logic [11:0] sdo;
		logic [7:0]  domain;
	} key_t;

endpackage

FILE: rtl/ptp_measurement_cache_unit.sv
// ----------------------------------------------------------------------------
// PTP measurement cache
// Ring of PTP exchange records with key search and delay/offset arithmetic.
// ----------------------------------------------------------------------------
// The cache holds ENTRIES records, each a key and four timestamps t1..t4.
// A push overwrites the entry under the ring pointer, clears its stamps and
// returns it; a record or query compares one entry per cycle from entry 0 up
// and the first valid match wins; a record stores the chosen stamp into it.
// Every item gives one result: hit, index, completeness and the halved path
// delay, link delay and offset (truncated toward zero, differences wrap).
// A push reads the stamps and runs the arithmetic; a record or query scans
// first and a miss goes straight to the result. The scan compares one entry
// a cycle, the four stamps come one a cycle from a stamp memory with one
// write and one registered read port, and one shared 64-bit adder runs eight
// steps. The next item is taken while a finished result still waits at the output.
`include "ptp_measurement_cache_unit_macros.svh"

module ptp_measurement_cache_unit #(
	parameter int ENTRIES = ptpmc_pkg::DEF_ENTRIES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// domain[7:0], sdo_id[19:8], seq_id[35:20], port_clock[99:36],
	// port_num[115:100], stamp_value[179:116], zero fill[183:180]
	input  logic [ptpmc_pkg::IN_W-1:0]   s_tdata,
	// func[1:0], stamp_sel[3:2]
	input  logic [3:0]                   s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// hit[0], entry_index[2:1], complete[3], path_delay[67:4],
	// link_delay[131:68], clock_offset[195:132], zero fill[199:196]
	output logic [ptpmc_pkg::OUT_W-1:0]  m_tdata
);

	localparam int IW    = $clog2(ENTRIES);
	localparam int AW    = IW + 2;
	localparam int DEPTH = ENTRIES * 4;
	localparam int TW    = ptpmc_pkg::TIME_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ,
		ST_CALC,
		ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		AS_D21,
		AS_D43,
		AS_LNK,
		AS_PSUM,
		AS_OSUM,
		AS_PHALF,
		AS_OHALF,
		AS_LHALF
	} alu_step_t;

	state_t    state_q;
	alu_step_t step_q;

	logic [IW-1:0]      wp_q;
	logic [IW-1:0]      idx_q;
	logic [2:0]         rcnt_q;
	logic               hit_q;
	logic               m_tvalid_q;
	logic [ENTRIES-1:0] entry_valid_q;
	logic [DEPTH-1:0]   stamp_vld_q;

	// item registers
	logic [ptpmc_pkg::FUNC_W-1:0] func_q;
	logic [ptpmc_pkg::SEL_W-1:0]  sel_q;
	logic [TW-1:0]                val_q;
	ptpmc_pkg::key_t              in_key_q;
	ptpmc_pkg::key_t              key_q [ENTRIES];

	// stamp memory
	logic [TW-1:0] stamp_mem [DEPTH];
	logic [TW-1:0] rd_q;
	logic          rd_vld_q;

	logic [TW-1:0] t_q [4];
	logic [TW-1:0] d21_q;
	logic [TW-1:0] d43_q;
	logic [TW-1:0] lnk_q;
	logic [TW-1:0] pth_q;
	logic [TW-1:0] off_q;
	logic          cmpl_q;
	logic [ptpmc_pkg::OUT_W-1:0] m_tdata_q;

	logic                         accept;
	logic [ptpmc_pkg::FUNC_W-1:0] in_func;
	ptpmc_pkg::key_t              in_key;
	logic                         match;
	logic                         last_entry;
	logic                         mem_we;
	logic [AW-1:0]                mem_waddr;
	logic [AW-1:0]                mem_raddr;
	logic [TW-1:0]                rd_val;
	logic                         out_load;
	logic [TW-1:0]                alu_a;
	logic [TW-1:0]                alu_b;
	logic                         alu_sub;
	logic                         alu_rnd;
	logic                         alu_cin;
	logic [TW-1:0]                alu_sum;
	logic [TW-1:0]                alu_half;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign in_func  = s_tuser[1:0];
	assign in_key   = ptpmc_pkg::key_t'(s_tdata[115:0]);

	assign match      = entry_valid_q[idx_q] && (key_q[idx_q] == in_key_q);
	assign last_entry = (idx_q == IW'(ENTRIES - 1));

	assign mem_we    = (state_q == ST_SCAN) && match && (func_q == ptpmc_pkg::FUNC_RECORD);
	assign mem_waddr = {idx_q, sel_q};
	assign mem_raddr = {idx_q, rcnt_q[1:0]};
	assign rd_val    = rd_vld_q ? rd_q : '0;

	assign out_load = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);

	// shared adder: a + b, a - b, or a plus its sign bit ahead of a halving
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		alu_rnd = 1'b0;
		case (step_q)
			AS_D21: begin
				alu_a   = t_q[1];
				alu_b   = t_q[0];
				alu_sub = 1'b1;
			end
			AS_D43: begin
				alu_a   = t_q[3];
				alu_b   = t_q[2];
				alu_sub = 1'b1;
			end
			AS_LNK: begin
				alu_a   = t_q[3];
				alu_b   = t_q[0];
				alu_sub = 1'b1;
			end
			AS_PSUM: begin
				alu_a = d21_q;
				alu_b = d43_q;
			end
			AS_OSUM: begin
				alu_a   = d21_q;
				alu_b   = d43_q;
				alu_sub = 1'b1;
			end
			AS_PHALF: begin
				alu_a   = pth_q;
				alu_rnd = 1'b1;
			end
			AS_OHALF: begin
				alu_a   = off_q;
				alu_rnd = 1'b1;
			end
			AS_LHALF: begin
				alu_a   = lnk_q;
				alu_rnd = 1'b1;
			end
			default: alu_a = '0;
		endcase
		alu_cin  = alu_sub | (alu_rnd & alu_a[TW-1]);
		alu_sum  = alu_a + (alu_sub ? ~alu_b : alu_b) + TW'(alu_cin);
		alu_half = TW'($signed(alu_sum) >>> 1);
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			step_q        <= AS_D21;
			wp_q          <= '0;
			idx_q         <= '0;
			rcnt_q        <= '0;
			hit_q         <= 1'b0;
			m_tvalid_q    <= 1'b0;
			entry_valid_q <= '0;
			stamp_vld_q   <= '0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rcnt_q <= '0;
						if (in_func == ptpmc_pkg::FUNC_PUSH) begin
							entry_valid_q[wp_q] <= 1'b1;
							for (int k = 0; k < 4; k++) begin
								stamp_vld_q[{wp_q, 2'(k)}] <= 1'b0;
							end
							idx_q   <= wp_q;
							wp_q    <= (wp_q == IW'(ENTRIES - 1)) ? '0 : wp_q + 1'b1;
							hit_q   <= 1'b1;
							state_q <= ST_READ;
						end else if (in_func == ptpmc_pkg::FUNC_NONE) begin
							hit_q   <= 1'b0;
							state_q <= ST_FIN;
						end else begin
							idx_q   <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (match) begin
						hit_q <= 1'b1;
						if (func_q == ptpmc_pkg::FUNC_RECORD) begin
							stamp_vld_q[mem_waddr] <= 1'b1;
						end
						state_q <= ST_READ;
					end else if (last_entry) begin
						hit_q   <= 1'b0;
						state_q <= ST_FIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_READ: begin
					rcnt_q <= rcnt_q + 3'd1;
					if (rcnt_q == 3'd4) begin
						step_q  <= AS_D21;
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					step_q <= alu_step_t'(step_q + 3'd1);
					if (step_q == AS_LHALF) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item, key and arithmetic registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= in_func;
			sel_q    <= s_tuser[3:2];
			val_q    <= s_tdata[179:116];
			in_key_q <= in_key;
			if (in_func == ptpmc_pkg::FUNC_PUSH) begin
				key_q[wp_q] <= in_key;
			end
		end
		if (state_q == ST_READ && rcnt_q != 3'd0) begin
			t_q[2'(rcnt_q - 3'd1)] <= rd_val;
			cmpl_q <= (rcnt_q == 3'd1) ? (rd_val != '0) : (cmpl_q && (rd_val != '0));
		end
		if (state_q == ST_CALC) begin
			case (step_q)
				AS_D21:   d21_q <= alu_sum;
				AS_D43:   d43_q <= alu_sum;
				AS_LNK:   lnk_q <= alu_sum;
				AS_PSUM:  pth_q <= alu_sum;
				AS_OSUM:  off_q <= alu_sum;
				AS_PHALF: pth_q <= alu_half;
				AS_OHALF: off_q <= alu_half;
				AS_LHALF: lnk_q <= alu_half;
				default:  d21_q <= d21_q;
			endcase
		end
		if (out_load) begin
			if (hit_q) begin
				m_tdata_q <= {4'b0, off_q, lnk_q, pth_q, cmpl_q, 2'(idx_q), 1'b1};
			end else begin
				m_tdata_q <= '0;
			end
		end
	end

	// stamp memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stamp_mem[mem_waddr] <= val_q;
		end
		rd_q     <= stamp_mem[mem_raddr];
		rd_vld_q <= stamp_vld_q[mem_raddr];
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`PMC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`PMC_ASSERT_SAME(a_wp_in_range, clk, arst_n, 1'b1, wp_q <= IW'(ENTRIES - 1))
	`PMC_ASSERT_NEXT(a_push_sets_valid, clk, arst_n, accept && in_func == ptpmc_pkg::FUNC_PUSH, entry_valid_q[$past(wp_q)])
	`PMC_ASSERT_SAME(a_result_from_fin, clk, arst_n, $rose(m_tvalid_q), $past(state_q == ST_FIN))
	`PMC_ASSERT_SAME(a_record_needs_match, clk, arst_n, mem_we, entry_valid_q[idx_q])

endmodule
